// ----- design/qrs_pkg.sv -----
// Package for the quadratic root solver: shared constants, result codes and
// the solution-kind enum. No dependencies.
`default_nettype none
package qrs_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int          THR_W     = 31;
    localparam logic [30:0] THR_RESET = 31'd1;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_LINEAR,
        KIND_DOUBLE,
        KIND_TWO
    } t_kind;

endpackage
`default_nettype wire

// ----- design/qrs_in_if.sv -----
// Coefficient channel of the quadratic root solver: valid/ready plus a, b, c.
// No dependencies.
`default_nettype none
interface qrs_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] coef_a;
    logic signed [DATA_WIDTH-1:0] coef_b;
    logic signed [DATA_WIDTH-1:0] coef_c;

    modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
    modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface
`default_nettype wire

// ----- design/qrs_out_if.sv -----
// Result channel of the quadratic root solver: valid/ready plus count, roots
// and saturation flag. No dependencies.
`default_nettype none
interface qrs_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   root_count;
    logic signed [DATA_WIDTH-1:0] root_first;
    logic signed [DATA_WIDTH-1:0] root_second;
    logic                         saturated;

    modport source (output valid, output root_count, output root_first,
                    output root_second, output saturated, input ready);
    modport sink   (input valid, input root_count, input root_first,
                    input root_second, input saturated, output ready);
endinterface
`default_nettype wire

// ----- design/qrs_div.sv -----
// Pipelined rounding divider: round(num/den) ties away from zero, one quotient
// bit per stage, then clip to the signed word and apply the sign. Uses qrs_pkg.
`default_nettype none
module qrs_div #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int TAG_W      = 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_act,
    input  wire logic                      i_neg,
    input  wire logic [DATA_WIDTH+FRAC_BITS+1:0] i_num,
    input  wire logic [DATA_WIDTH:0]       i_den,
    input  wire logic [TAG_W-1:0]          i_tag,
    output logic signed [DATA_WIDTH-1:0]   o_root,
    output logic                           o_sat,
    output logic [TAG_W-1:0]               o_tag
);
    import qrs_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int NW  = W + FRAC_BITS + 2;
    localparam int N2W = NW + 2;
    localparam int D2W = W + 2;
    localparam int QW  = W + 1;

    logic [N2W-1:0] r_n    [0:N2W];
    logic [D2W-1:0] r_rem  [0:N2W];
    logic [D2W-1:0] r_d2   [0:N2W];
    logic [QW-1:0]  r_q    [0:N2W];
    logic           r_ovf  [0:N2W];
    logic           r_neg  [0:N2W];
    logic           r_act  [0:N2W];
    logic [TAG_W-1:0] r_tag [0:N2W+1];

    logic [D2W:0]   s_remx [0:N2W-1];
    logic           s_ge   [0:N2W-1];

    logic [QW-1:0]  s_lim;
    logic [QW-1:0]  s_qc;
    logic           s_sat;
    logic [W-1:0]   n_root;
    logic signed [W-1:0] r_root;
    logic           r_sat;

    always_comb begin
        for (int k = 0; k < N2W; k++) begin
            s_remx[k] = {r_rem[k], r_n[k][N2W-1]};
            s_ge[k]   = (s_remx[k] >= {1'b0, r_d2[k]});
        end
    end

    always_comb begin
        s_lim = QW'(1) << (W - 1);
        if (!r_neg[N2W]) begin
            s_lim = s_lim - QW'(1);
        end
        s_sat  = r_ovf[N2W] | (r_q[N2W] > s_lim);
        s_qc   = s_sat ? s_lim : r_q[N2W];
        n_root = r_neg[N2W] ? (W'(0) - s_qc[W-1:0]) : s_qc[W-1:0];
        if (!r_act[N2W]) begin
            n_root = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]   <= {1'b0, i_num, 1'b0} + N2W'(i_den);
            r_d2[0]  <= {i_den, 1'b0};
            r_rem[0] <= '0;
            r_q[0]   <= '0;
            r_ovf[0] <= 1'b0;
            r_neg[0] <= i_neg;
            r_act[0] <= i_act;
            for (int k = 0; k < N2W; k++) begin
                r_n[k+1]   <= r_n[k] << 1;
                r_d2[k+1]  <= r_d2[k];
                r_rem[k+1] <= s_ge[k] ? D2W'(s_remx[k] - {1'b0, r_d2[k]})
                                      : D2W'(s_remx[k]);
                r_q[k+1]   <= {r_q[k][QW-2:0], s_ge[k]};
                r_ovf[k+1] <= r_ovf[k] | r_q[k][QW-1];
                r_neg[k+1] <= r_neg[k];
                r_act[k+1] <= r_act[k];
            end
            r_root <= n_root;
            r_sat  <= s_sat & r_act[N2W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N2W + 1; k++) begin
                r_tag[k] <= '0;
            end
        end else if (i_en) begin
            r_tag[0] <= i_tag;
            for (int k = 0; k <= N2W; k++) begin
                r_tag[k+1] <= r_tag[k];
            end
        end
    end

    assign o_root = r_root;
    assign o_sat  = r_sat;
    assign o_tag  = r_tag[N2W+1];

endmodule
`default_nettype wire

// ----- design/quadratic_root_solver_core.sv -----
// Quadratic root solver core: real roots of a*x^2+b*x+c in signed fixed point
// (Q16.16 by default): sqrt one bit/stage, division one quotient bit/stage.
// Throughput one item per cycle; a stall on the result side freezes the whole
// pipe. Synchronous active-low reset clears valid bits and sets the zero
// threshold to 1. Uses qrs_pkg, qrs_div, ifs.
`default_nettype none
module quadratic_root_solver_core #(
    parameter int DATA_WIDTH = qrs_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [qrs_pkg::THR_W-1:0] i_cfg_wdata,
    qrs_in_if.sink                        i_coef,
    qrs_out_if.source                     o_root
);
    import qrs_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DW  = 2 * W + 2;
    localparam int SW  = W + 1;
    localparam int TW  = (W > THR_W) ? W : THR_W;
    localparam int CW  = (DW > THR_W + F) ? DW : THR_W + F;
    localparam int XW  = W + 3;
    localparam int NW  = W + F + 2;

    logic [THR_W-1:0] r_thr;
    logic             s_en;

    // stage 1: magnitudes and coefficient tests
    logic         r_v1, r_sa1, r_sb1, r_sc1, r_as1, r_bb1;
    logic [W-1:0] r_ma1, r_mb1, r_mc1;
    logic [W-1:0] n_ma, n_mb, n_mc;

    // stage 2: products
    logic           r_v2, r_sa2, r_sb2, r_sc2, r_as2, r_bb2;
    logic [W-1:0]   r_ma2, r_mb2, r_mc2;
    logic [2*W-1:0] r_p2, r_ac2;

    // stage 3 and sqrt stages
    logic [DW-1:0]  n_d;
    logic           n_dneg;
    t_kind          n_kind;
    logic [CW-1:0]  s_tcmp;
    logic [DW-1:0]  s_px, s_q4;

    logic           r_sv   [0:SW];
    logic [DW-1:0]  r_sd   [0:SW];
    logic [SW+1:0]  r_srem [0:SW];
    logic [SW-1:0]  r_sroot[0:SW];
    logic [W-1:0]   r_sma  [0:SW];
    logic [W-1:0]   r_smb  [0:SW];
    logic [W-1:0]   r_smc  [0:SW];
    logic           r_ssa  [0:SW];
    logic           r_ssb  [0:SW];
    logic           r_ssc  [0:SW];
    t_kind          r_skind[0:SW];
    logic [SW+3:0]  s_remx [0:SW-1];
    logic [SW+3:0]  s_trial[0:SW-1];
    logic           s_ge   [0:SW-1];

    // stage 4: divider operands
    logic [XW-1:0]  s_bs, s_sx, s_n1, s_n2;
    logic [W+1:0]   s_m1, s_m2;
    logic [NW-1:0]  n_num1, n_num2, r_num1, r_num2;
    logic [W:0]     n_den, r_den;
    logic           n_neg1, n_neg2, n_act1, n_act2;
    logic           r_neg1, r_neg2, r_act1, r_act2, r_v4;
    logic [1:0]     n_cnt, r_cnt;
    t_kind          s_kind4;

    logic [1:0]     s_cnt_out;
    logic [0:0]     s_vld_out;
    logic signed [W-1:0] s_r1, s_r2;
    logic           s_sat1, s_sat2;

    assign s_en         = !s_vld_out[0] || o_root.ready;
    assign i_coef.ready = s_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    always_comb begin
        n_ma = i_coef.coef_a[W-1] ? (W'(0) - i_coef.coef_a) : i_coef.coef_a;
        n_mb = i_coef.coef_b[W-1] ? (W'(0) - i_coef.coef_b) : i_coef.coef_b;
        n_mc = i_coef.coef_c[W-1] ? (W'(0) - i_coef.coef_c) : i_coef.coef_c;
    end

    // discriminant, exact, then classify
    always_comb begin
        s_px   = {2'b00, r_p2};
        s_q4   = {r_ac2, 2'b00};
        n_dneg = 1'b0;
        if (r_sa2 ^ r_sc2) begin
            n_d = s_px + s_q4;
        end else if (s_px >= s_q4) begin
            n_d = s_px - s_q4;
        end else begin
            n_d    = s_q4 - s_px;
            n_dneg = 1'b1;
        end
        s_tcmp = CW'(r_thr);
        s_tcmp = s_tcmp << F;
        if (r_as2) begin
            n_kind = r_bb2 ? KIND_LINEAR : KIND_NONE;
        end else if (CW'(n_d) <= s_tcmp) begin
            n_kind = KIND_DOUBLE;
        end else if (n_dneg) begin
            n_kind = KIND_NONE;
        end else begin
            n_kind = KIND_TWO;
        end
    end

    always_comb begin
        for (int k = 0; k < SW; k++) begin
            s_remx[k]  = {r_srem[k], r_sd[k][DW-1:DW-2]};
            s_trial[k] = {2'b00, r_sroot[k], 2'b01};
            s_ge[k]    = (s_remx[k] >= s_trial[k]);
        end
    end

    // numerators and the shared divisor for the two root dividers
    always_comb begin
        s_kind4 = r_skind[SW];
        s_bs    = r_ssb[SW] ? (XW'(0) - XW'(r_smb[SW])) : XW'(r_smb[SW]);
        s_sx    = XW'(r_sroot[SW]);
        s_n1    = s_sx - s_bs;
        s_n2    = XW'(0) - s_bs - s_sx;
        s_m1    = s_n1[XW-1] ? (W+2)'(XW'(0) - s_n1) : s_n1[W+1:0];
        s_m2    = s_n2[XW-1] ? (W+2)'(XW'(0) - s_n2) : s_n2[W+1:0];
        n_num1  = {s_m1, {F{1'b0}}};
        n_num2  = {s_m2, {F{1'b0}}};
        n_den   = {r_sma[SW], 1'b0};
        n_neg1  = s_n1[XW-1] ^ r_ssa[SW];
        n_neg2  = s_n2[XW-1] ^ r_ssa[SW];
        n_act1  = 1'b1;
        n_act2  = 1'b0;
        n_cnt   = CNT_ONE;
        case (s_kind4)
            KIND_LINEAR: begin
                n_num1 = {2'b00, r_smc[SW], {F{1'b0}}};
                n_den  = {1'b0, r_smb[SW]};
                n_neg1 = !(r_ssc[SW] ^ r_ssb[SW]);
            end
            KIND_DOUBLE: begin
                n_num1 = {2'b00, r_smb[SW], {F{1'b0}}};
                n_neg1 = !(r_ssb[SW] ^ r_ssa[SW]);
            end
            KIND_TWO: begin
                n_act2 = 1'b1;
                n_cnt  = CNT_TWO;
            end
            default: begin
                n_act1 = 1'b0;
                n_cnt  = CNT_NONE;
                n_den  = (W+1)'(1);
            end
        endcase
    end

    // payload registers, advance together with the valid bits
    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_ma1 <= n_ma;
            r_mb1 <= n_mb;
            r_mc1 <= n_mc;
            r_sa1 <= i_coef.coef_a[W-1];
            r_sb1 <= i_coef.coef_b[W-1];
            r_sc1 <= i_coef.coef_c[W-1];
            r_as1 <= TW'(n_ma) <= TW'(r_thr);
            r_bb1 <= TW'(n_mb) >  TW'(r_thr);

            r_ma2 <= r_ma1;
            r_mb2 <= r_mb1;
            r_mc2 <= r_mc1;
            r_sa2 <= r_sa1;
            r_sb2 <= r_sb1;
            r_sc2 <= r_sc1;
            r_as2 <= r_as1;
            r_bb2 <= r_bb1;
            r_p2  <= (2*W)'(r_mb1) * (2*W)'(r_mb1);
            r_ac2 <= (2*W)'(r_ma1) * (2*W)'(r_mc1);

            r_sd[0]    <= n_d;
            r_srem[0]  <= '0;
            r_sroot[0] <= '0;
            r_sma[0]   <= r_ma2;
            r_smb[0]   <= r_mb2;
            r_smc[0]   <= r_mc2;
            r_ssa[0]   <= r_sa2;
            r_ssb[0]   <= r_sb2;
            r_ssc[0]   <= r_sc2;
            r_skind[0] <= n_kind;
            for (int k = 0; k < SW; k++) begin
                r_sd[k+1]    <= r_sd[k] << 2;
                r_srem[k+1]  <= s_ge[k] ? (SW+2)'(s_remx[k] - s_trial[k])
                                        : (SW+2)'(s_remx[k]);
                r_sroot[k+1] <= {r_sroot[k][SW-2:0], s_ge[k]};
                r_sma[k+1]   <= r_sma[k];
                r_smb[k+1]   <= r_smb[k];
                r_smc[k+1]   <= r_smc[k];
                r_ssa[k+1]   <= r_ssa[k];
                r_ssb[k+1]   <= r_ssb[k];
                r_ssc[k+1]   <= r_ssc[k];
                r_skind[k+1] <= r_skind[k];
            end

            r_num1 <= n_num1;
            r_num2 <= n_num2;
            r_den  <= n_den;
            r_neg1 <= n_neg1;
            r_neg2 <= n_neg2;
            r_act1 <= n_act1;
            r_act2 <= n_act2;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v4 <= 1'b0;
            for (int k = 0; k <= SW; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else if (s_en) begin
            r_v1    <= i_coef.valid;
            r_v2    <= r_v1;
            r_sv[0] <= r_v2;
            for (int k = 0; k < SW; k++) begin
                r_sv[k+1] <= r_sv[k];
            end
            r_v4 <= r_sv[SW];
        end
    end

    qrs_div #(
        .DATA_WIDTH (W),
        .FRAC_BITS  (F),
        .TAG_W      (2)
    ) u_div_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_act   (r_act1),
        .i_neg   (r_neg1),
        .i_num   (r_num1),
        .i_den   (r_den),
        .i_tag   (r_cnt),
        .o_root  (s_r1),
        .o_sat   (s_sat1),
        .o_tag   (s_cnt_out)
    );

    qrs_div #(
        .DATA_WIDTH (W),
        .FRAC_BITS  (F),
        .TAG_W      (1)
    ) u_div_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (s_en),
        .i_act   (r_act2),
        .i_neg   (r_neg2),
        .i_num   (r_num2),
        .i_den   (r_den),
        .i_tag   (r_v4),
        .o_root  (s_r2),
        .o_sat   (s_sat2),
        .o_tag   (s_vld_out)
    );

    assign o_root.valid       = s_vld_out[0];
    assign o_root.root_count  = s_cnt_out;
    assign o_root.root_first  = s_r1;
    assign o_root.root_second = s_r2;
    assign o_root.saturated   = s_sat1 | s_sat2;

endmodule
`default_nettype wire
